// ===== rtl/core/log_law_wall_viscosity_macros.svh =====
// ---------------------------------------------------------------------------
// log-law wall viscosity assertion macros
// shared property forms for the wall viscosity core
// ---------------------------------------------------------------------------
`ifndef LOG_LAW_WALL_VISCOSITY_MACROS_SVH
`define LOG_LAW_WALL_VISCOSITY_MACROS_SVH

// same-cycle implication, disabled while in reset
`define LLWV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("llwv assertion failed");

// next-cycle implication, disabled while in reset
`define LLWV_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("llwv assertion failed");

`endif

// ===== rtl/core/llwv_pkg.sv =====
// ---------------------------------------------------------------------------
// llwv_pkg
// types and constants of the log-law wall viscosity core
// ---------------------------------------------------------------------------
`default_nettype none

package llwv_pkg;

    localparam int SQ_STEPS  = 24;  // fraction bits of log2
    localparam int DIV_STEPS = 32;  // quotient bits

    // ln 2 in q0.32, rounded to nearest
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    // register indexes
    localparam logic [1:0] CFG_KAPPA   = 2'd0;
    localparam logic [1:0] CFG_LOG_E   = 2'd1;
    localparam logic [1:0] CFG_LAMINAR = 2'd2;

    localparam logic [15:0] KAPPA_RST   = 16'd26870;
    localparam logic [23:0] LOG_E_RST   = 24'd589824;
    localparam logic [31:0] LAMINAR_RST = 32'd11770266;

    // exponent offset of the q20.36 product
    localparam logic [5:0] EXP_BIAS = 6'd36;
    localparam logic [5:0] NORM_POS = 6'd30;

    // fields that ride along every stage after the product sum
    typedef struct packed {
        logic        valid;
        logic        laminar;
        logic [31:0] nu;
        logic [79:0] num;
    } t_carry;

endpackage

`default_nettype wire

// ===== rtl/core/log_law_wall_viscosity.sv =====
// ---------------------------------------------------------------------------
// log_law_wall_viscosity
// wall viscosity from the log-law wall function, fully pipelined
// ---------------------------------------------------------------------------
// One item (yplus, nu_cell) may be started in every clock cycle; busy never
// rises. Each item's result appears, marked by o_valid for one cycle, in
// start order. The receiver cannot stall, so the result must be taken in
// that cycle. The log2 unit has 24 squaring stages, one fraction bit each,
// and the restoring divider 32 stages, one quotient bit each. Configuration
// writes take effect for items started after the write.
`default_nettype none

`include "log_law_wall_viscosity_macros.svh"

module log_law_wall_viscosity
    import llwv_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] i_yplus,
    input  wire logic [31:0] i_nu_cell,
    output logic             o_valid,
    output logic [31:0]      o_nu_wall,
    output logic             o_in_log_region,
    output logic             o_error_flag
);

    // configuration registers
    logic [15:0] r_kappa;
    logic [23:0] r_log_e;
    logic [31:0] r_laminar;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kappa   <= KAPPA_RST;
            r_log_e   <= LOG_E_RST;
            r_laminar <= LAMINAR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KAPPA:   r_kappa   <= i_cfg_data[15:0];
                CFG_LOG_E:   r_log_e   <= i_cfg_data[23:0];
                CFG_LAMINAR: r_laminar <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    // the pipeline never stalls
    assign busy = 1'b0;

    // stage 1: laminar test, P = yplus * E, A = nu * kappa
    logic        r_s1_valid;
    logic        r_s1_lam;
    logic [55:0] r_s1_p;
    logic [47:0] r_s1_a;
    logic [31:0] r_s1_y;
    logic [31:0] r_s1_nu;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_lam <= (i_yplus < r_laminar);
        r_s1_p   <= 56'(i_yplus) * 56'(r_log_e);
        r_s1_a   <= 48'(i_nu_cell) * 48'(r_kappa);
        r_s1_y   <= i_yplus;
        r_s1_nu  <= i_nu_cell;
    end

    // stage 2: top set bit of P, partial products of A * yplus
    logic [5:0]  n_s2_m;
    logic        r_s2_valid;
    logic        r_s2_lam;
    logic [55:0] r_s2_p;
    logic [5:0]  r_s2_m;
    logic [63:0] r_s2_pl;
    logic [47:0] r_s2_ph;
    logic [31:0] r_s2_nu;

    always_comb begin
        n_s2_m = '0;
        for (int i = 0; i < 56; i++) begin
            if (r_s1_p[i]) begin
                n_s2_m = 6'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_lam <= r_s1_lam;
        r_s2_p   <= r_s1_p;
        r_s2_m   <= n_s2_m;
        r_s2_pl  <= 64'(r_s1_a[31:0]) * 64'(r_s1_y);
        r_s2_ph  <= 48'(r_s1_a[47:32]) * 48'(r_s1_y);
        r_s2_nu  <= r_s1_nu;
    end

    // stage 3: mantissa normalized to q1.30, full 80-bit numerator
    // squaring pipe: index 0 is stage 3, index k after k squarings
    t_carry      r_sq_c [0:SQ_STEPS];
    logic [30:0] r_sq_z [0:SQ_STEPS];
    logic [23:0] r_sq_f [0:SQ_STEPS];
    logic [5:0]  r_sq_m [0:SQ_STEPS];
    logic        r_sq_pz[0:SQ_STEPS];

    t_carry      n_s3_c;
    logic [30:0] n_s3_z;

    always_comb begin
        n_s3_c.valid   = r_s2_valid;
        n_s3_c.laminar = r_s2_lam;
        n_s3_c.nu      = r_s2_nu;
        n_s3_c.num     = 80'(r_s2_pl) + {r_s2_ph, 32'b0};
        if (r_s2_m >= NORM_POS) begin
            n_s3_z = 31'(r_s2_p >> (r_s2_m - NORM_POS));
        end else begin
            n_s3_z = 31'(r_s2_p << (NORM_POS - r_s2_m));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_c[0].valid <= 1'b0;
        end else begin
            r_sq_c[0] <= n_s3_c;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq_z[0]  <= n_s3_z;
        r_sq_f[0]  <= '0;
        r_sq_m[0]  <= r_s2_m;
        r_sq_pz[0] <= (r_s2_p == '0);
    end

    // one squaring per stage gives one fraction bit
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
        logic [61:0] n_sq;
        logic [31:0] n_zs;
        logic [30:0] n_z;
        logic [23:0] n_f;

        always_comb begin
            n_sq = 62'(r_sq_z[k]) * 62'(r_sq_z[k]);
            n_zs = n_sq[61:30];
            if (n_zs[31]) begin
                n_z = n_zs[31:1];
                n_f = {r_sq_f[k][22:0], 1'b1};
            end else begin
                n_z = n_zs[30:0];
                n_f = {r_sq_f[k][22:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_c[k+1].valid <= 1'b0;
            end else begin
                r_sq_c[k+1] <= r_sq_c[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_sq_z[k+1]  <= n_z;
            r_sq_f[k+1]  <= n_f;
            r_sq_m[k+1]  <= r_sq_m[k];
            r_sq_pz[k+1] <= r_sq_pz[k];
        end
    end

    // ln stage: L = (m - 36) * 2^24 + frac, LN = L * ln2 when L is positive
    t_carry      r_ln_c;
    logic [28:0] r_ln_v;

    logic        n_ln_pos;
    logic [28:0] n_ln_l;
    logic [60:0] n_ln_prod;
    logic [28:0] n_ln_v;

    always_comb begin
        n_ln_pos = !r_sq_pz[SQ_STEPS] &&
                   ((r_sq_m[SQ_STEPS] > EXP_BIAS) ||
                    ((r_sq_m[SQ_STEPS] == EXP_BIAS) && (r_sq_f[SQ_STEPS] != '0)));
        n_ln_l    = {5'(r_sq_m[SQ_STEPS] - EXP_BIAS), r_sq_f[SQ_STEPS]};
        n_ln_prod = 61'(n_ln_l) * 61'(LN2_Q32);
        n_ln_v    = n_ln_pos ? n_ln_prod[60:32] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ln_c.valid <= 1'b0;
        end else begin
            r_ln_c <= r_sq_c[SQ_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_ln_v <= n_ln_v;
    end

    // divider: index 0 is the setup stage, index k after k quotient bits
    t_carry      r_dv_c  [0:DIV_STEPS];
    logic [40:0] r_dv_d  [0:DIV_STEPS];
    logic [40:0] r_dv_r  [0:DIV_STEPS];
    logic [31:0] r_dv_q  [0:DIV_STEPS];
    logic        r_dv_bad[0:DIV_STEPS];
    logic        r_dv_sat[0:DIV_STEPS];

    logic [40:0] n_dv_d;
    logic        n_dv_bad;

    // quotient overflows 32 bits exactly when num / 2^32 >= d
    always_comb begin
        n_dv_d   = {r_ln_v, 12'b0};
        n_dv_bad = (r_ln_v == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_c[0].valid <= 1'b0;
        end else begin
            r_dv_c[0] <= r_ln_c;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dv_d[0]   <= n_dv_d;
        r_dv_r[0]   <= r_ln_c.num[72:32];
        r_dv_q[0]   <= '0;
        r_dv_bad[0] <= n_dv_bad;
        r_dv_sat[0] <= !n_dv_bad && (r_ln_c.num[79:32] >= 48'(n_dv_d));
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_dv
        logic [41:0] n_t;
        logic        n_ge;

        always_comb begin
            n_t  = {r_dv_r[k], r_dv_c[k].num[DIV_STEPS-1-k]};
            n_ge = (n_t >= 42'(r_dv_d[k]));
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_c[k+1].valid <= 1'b0;
            end else begin
                r_dv_c[k+1] <= r_dv_c[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_dv_d[k+1]   <= r_dv_d[k];
            r_dv_r[k+1]   <= n_ge ? 41'(n_t - 42'(r_dv_d[k])) : n_t[40:0];
            r_dv_q[k+1]   <= {r_dv_q[k][30:0], n_ge};
            r_dv_bad[k+1] <= r_dv_bad[k];
            r_dv_sat[k+1] <= r_dv_sat[k];
        end
    end

    // output register: pick laminar, bad log, saturation or quotient
    logic        r_o_valid;
    logic [31:0] r_o_nu;
    logic        r_o_log;
    logic        r_o_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= r_dv_c[DIV_STEPS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_log <= !r_dv_c[DIV_STEPS].laminar;
        r_o_err <= !r_dv_c[DIV_STEPS].laminar &&
                   (r_dv_bad[DIV_STEPS] || r_dv_sat[DIV_STEPS]);
        if (r_dv_c[DIV_STEPS].laminar || r_dv_bad[DIV_STEPS]) begin
            r_o_nu <= r_dv_c[DIV_STEPS].nu;
        end else if (r_dv_sat[DIV_STEPS]) begin
            r_o_nu <= '1;
        end else begin
            r_o_nu <= r_dv_q[DIV_STEPS];
        end
    end

    assign o_valid         = r_o_valid;
    assign o_nu_wall       = r_o_nu;
    assign o_in_log_region = r_o_log;
    assign o_error_flag    = r_o_err;

    // a started item enters the first stage
    `LLWV_ASSERT_NXT(a_start_enters, i_clk, i_rst_n, start, r_s1_valid)
    // the last divider stage always reaches the output
    `LLWV_ASSERT_NXT(a_div_to_out, i_clk, i_rst_n, r_dv_c[DIV_STEPS].valid, o_valid)
    // a bad logarithm never also reports saturation
    `LLWV_ASSERT_IMP(a_bad_not_sat, i_clk, i_rst_n, r_dv_c[0].valid && r_dv_bad[0],
        !r_dv_sat[0])
    // laminar items never carry the error flag
    `LLWV_ASSERT_IMP(a_lam_no_err, i_clk, i_rst_n, o_valid && !o_in_log_region,
        !o_error_flag)

endmodule

`default_nettype wire

// ===== tb/tb_log_law_wall_viscosity.sv =====
// ----------------------------------------------------------------------------
// log-law wall viscosity testbench
// streams wall node items through the core, predicts each wall viscosity in
// fixed point and compares every result field against the predicted value
// ----------------------------------------------------------------------------
`default_nettype none

module tb_log_law_wall_viscosity;
    import llwv_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 62;

    typedef struct {
        logic [31:0] yplus;
        logic [31:0] nu_cell;
        bit          is_cfg;    // register write, driven only when the core is idle
        logic [1:0]  cfg_idx;
        logic [31:0] cfg_data;
    } t_node;

    typedef struct {
        logic [31:0] nu_wall;
        logic        in_log;
        logic        err;
    } t_wall;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;
    logic        start;
    logic        busy;
    logic [31:0] i_yplus;
    logic [31:0] i_nu_cell;
    logic        o_valid;
    logic [31:0] o_nu_wall;
    logic        o_in_log_region;
    logic        o_error_flag;

    log_law_wall_viscosity uut (.*);

    // predictor copies of the registers
    logic [15:0] kappa_q = KAPPA_RST;
    logic [23:0] e_q     = LOG_E_RST;
    logic [31:0] lam_q   = LAMINAR_RST;

    t_node pending_nodes[$];
    t_wall expected_walls[$];
    int    errors = 0;
    int    send_idle = 31;   // percent of cycles the driver holds off
    int    drain_cnt = 0;
    logic [31:0] lam_hint = LAMINAR_RST;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // log2 of the q20.36 product as signed q8.24
    function automatic longint log2_q24(logic [63:0] p);
        int          m;
        logic [63:0] z;
        longint      frac;
        m = 0;
        for (int b = 0; b < 64; b++) if (p[b]) m = b;
        z = (m >= 30) ? (p >> (m - 30)) : (p << (30 - m));
        frac = 0;
        for (int i = 0; i < 24; i++) begin
            z = (z * z) >> 30;
            frac = frac << 1;
            if (z >= 64'h8000_0000) begin
                z = z >> 1;
                frac = frac | 1;
            end
        end
        return longint'(m - 36) * 64'sd16777216 + frac;
    endfunction

    function automatic t_wall predict_wall(logic [31:0] yp, logic [31:0] nu);
        t_wall        w;
        logic [63:0]  p;
        longint       l;
        logic [95:0]  lnq;
        logic [127:0] num, quo;
        w.nu_wall = nu;
        w.in_log  = 1'b0;
        w.err     = 1'b0;
        if (yp < lam_q) return w;
        w.in_log = 1'b1;
        p = 64'(yp) * 64'(e_q);
        lnq = 0;
        if (p != 0) begin
            l = log2_q24(p);
            if (l > 0) lnq = (96'(l) * 96'(LN2_Q32)) >> 32;
        end
        if (lnq == 0) begin
            w.err = 1'b1;
            return w;
        end
        num = 128'(nu) * 128'(kappa_q) * 128'(yp);
        quo = num / 128'(lnq << 12);
        if (quo > 128'hFFFF_FFFF) begin
            w.nu_wall = 32'hFFFF_FFFF;
            w.err     = 1'b1;
        end else begin
            w.nu_wall = quo[31:0];
        end
        return w;
    endfunction

    // driver: one item or register write per accepted edge
    always @(posedge i_clk) begin
        t_node n;
        bit    we;
        if (!i_rst_n) begin
            start      <= 1'b0;
            i_cfg_we   <= 1'b0;
            i_cfg_idx  <= CFG_KAPPA;
            i_cfg_data <= '0;
            i_yplus    <= '0;
            i_nu_cell  <= '0;
        end else begin
            // an item is taken on this edge when start was high and busy low
            we = 1'b0;
            if ((!start || !busy) && pending_nodes.size() != 0 &&
                    $urandom_range(99) >= send_idle) begin
                n = pending_nodes[0];
                if (n.is_cfg) begin
                    // register writes wait for the pipeline to drain
                    if (expected_walls.size() == 0 && drain_cnt >= LATENCY) begin
                        void'(pending_nodes.pop_front());
                        start      <= 1'b0;
                        we         = 1'b1;
                        i_cfg_idx  <= n.cfg_idx;
                        i_cfg_data <= n.cfg_data;
                        case (n.cfg_idx)
                            CFG_KAPPA:   kappa_q = n.cfg_data[15:0];
                            CFG_LOG_E:   e_q     = n.cfg_data[23:0];
                            CFG_LAMINAR: lam_q   = n.cfg_data;
                            default: ;
                        endcase
                    end else begin
                        start <= 1'b0;
                    end
                end else begin
                    void'(pending_nodes.pop_front());
                    start     <= 1'b1;
                    i_yplus   <= n.yplus;
                    i_nu_cell <= n.nu_cell;
                    expected_walls.push_back(predict_wall(n.yplus, n.nu_cell));
                end
            end else if (!start || !busy) begin
                start <= 1'b0;
            end
            i_cfg_we <= we;
        end
    end

    // counts quiet cycles since the last start, to let the pipeline empty
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy)) drain_cnt <= 0;
        else if (drain_cnt < 1000) drain_cnt <= drain_cnt + 1;
    end

    // monitor: every strobed result against the oldest prediction
    always @(posedge i_clk) begin
        t_wall w;
        if (i_rst_n && o_valid) begin
            if (expected_walls.size() == 0) begin
                $error("result with no item outstanding: nu_wall %h", o_nu_wall);
                errors++;
            end else begin
                w = expected_walls.pop_front();
                if (o_nu_wall !== w.nu_wall) begin
                    $error("nu_wall expected %h actual %h", w.nu_wall, o_nu_wall);
                    errors++;
                end
                if (o_in_log_region !== w.in_log) begin
                    $error("in_log_region expected %b actual %b", w.in_log,
                           o_in_log_region);
                    errors++;
                end
                if (o_error_flag !== w.err) begin
                    $error("error_flag expected %b actual %b", w.err, o_error_flag);
                    errors++;
                end
            end
        end
    end

    task automatic add_node(logic [31:0] yp, logic [31:0] nu);
        t_node n;
        n.yplus = yp; n.nu_cell = nu; n.is_cfg = 0; n.cfg_idx = CFG_KAPPA;
        n.cfg_data = 0;
        pending_nodes.push_back(n);
    endtask

    task automatic add_write(logic [1:0] idx, logic [31:0] data);
        t_node n;
        n.yplus = 0; n.nu_cell = 0; n.is_cfg = 1; n.cfg_idx = idx; n.cfg_data = data;
        pending_nodes.push_back(n);
    endtask

    // random y-plus, mostly near the useful range, sometimes any value
    function automatic logic [31:0] rand_yplus();
        case ($urandom_range(3))
            0: return $urandom();
            1: return lam_hint + $urandom_range(32'h0400_0000);
            2: return $urandom_range(32'h0200_0000);
            default: return lam_hint - $urandom_range(32'h0010_0000);
        endcase
    endfunction

    function automatic logic [31:0] rand_nu();
        case ($urandom_range(2))
            0: return $urandom();
            1: return $urandom_range(32'h0100_0000);
            default: return $urandom() >> $urandom_range(31);
        endcase
    endfunction

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++) add_node(rand_yplus(), rand_nu());
    endtask

    task automatic wait_drained();
        while (pending_nodes.size() != 0 || expected_walls.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: laminar edge, zero product, extremes, zero kappa and nu
        add_node(32'd0, 32'hFFFF_FFFF);
        add_node(LAMINAR_RST - 1, 32'h1234_5678);
        add_node(LAMINAR_RST, 32'h0100_0000);
        add_node(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_node(32'hFFFF_FFFF, 32'd0);
        add_node(32'h0100_0000, 32'h0000_0001);
        add_write(CFG_LAMINAR, 32'd0);
        add_node(32'd0, 32'hAAAA_5555);              // zero product
        add_node(32'd1, 32'h5555_AAAA);              // log below zero
        add_node(32'h0002_0000, 32'h0100_0000);
        add_write(CFG_LOG_E, 32'h0001_0000);         // e = 1.0
        add_node(32'h0010_0000, 32'h0100_0000);      // ln(1) = 0
        add_node(32'h0010_0001, 32'hFFFF_FFFF);      // tiny log, saturates
        add_write(CFG_KAPPA, 32'd0);
        add_node(32'h0400_0000, 32'hFFFF_FFFF);      // zero kappa
        add_write(CFG_KAPPA, 32'hFFFF);
        add_write(CFG_LOG_E, 32'hFF_FFFF);
        add_node(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_node(32'h8000_0000, 32'h0000_0000);
        add_write(CFG_LOG_E, 32'd1);
        add_node(32'hFFFF_FFFF, 32'h0100_0000);
        add_write(CFG_LAMINAR, 32'hFFFF_FFFF);
        add_node(32'hFFFF_FFFE, 32'h0100_0000);
        add_node(32'hFFFF_FFFF, 32'h0100_0000);
        wait_drained();

        // random phases over several settings, sender busy, then quiet, then never idle
        add_write(CFG_KAPPA, KAPPA_RST);
        add_write(CFG_LOG_E, LOG_E_RST);
        add_write(CFG_LAMINAR, LAMINAR_RST);
        lam_hint = LAMINAR_RST;
        random_phase(280);
        wait_drained();           // sender pauses until all results are in
        send_idle = 78;
        add_write(CFG_KAPPA, $urandom_range(1, 16'hFFFF));
        add_write(CFG_LOG_E, $urandom_range(1, 24'hFF_FFFF));
        lam_hint = $urandom_range(32'h0400_0000);
        add_write(CFG_LAMINAR, lam_hint);
        random_phase(280);
        wait_drained();
        send_idle = 0;
        add_write(CFG_KAPPA, 32'd1);
        add_write(CFG_LOG_E, 32'hFF_FFFF);
        lam_hint = 32'h0001_0000;
        add_write(CFG_LAMINAR, lam_hint);
        random_phase(270);
        wait_drained();

        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0 && expected_walls.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/llwv_pkg.sv
rtl/core/log_law_wall_viscosity.sv
tb/tb_log_law_wall_viscosity.sv
